>>> hdl/assert_macros.svh
// Shared assertion macros for the texel address pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define RFTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RFTA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rfta_pkg.sv
`timescale 1ns / 1ps
package rfta_pkg;

  localparam int unsigned TEX_WIDTH_DEF  = 64;
  localparam int unsigned TEX_HEIGHT_DEF = 64;

  // register indexes
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
  localparam logic [1:0] REG_PLAYER_X      = 2'd1;
  localparam logic [1:0] REG_PLAYER_Y      = 2'd2;

  // ray x direction codes
  localparam logic [1:0] DIR_X_POS = 2'd0;
  localparam logic [1:0] DIR_X_NEG = 2'd1;

  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [16:0] ONE_Q16           = 17'h10000;

  localparam int unsigned DIST_W = 28;  // Q12.16 row distance
  localparam int unsigned WQ_W   = 18;  // weight quotient bits
  localparam int unsigned POS_W  = 25;  // Q9.16 map position

  typedef struct packed {
    logic [10:0]      row;
    logic [10:0]      column;
    logic [10:0]      ceil_row;
    logic             vres;
    logic [POS_W-1:0] wall_x;
    logic [POS_W-1:0] wall_y;
  } pix_t;

  typedef struct packed {
    pix_t        pix;
    logic [23:0] wdist;
  } div1_side_t;

  typedef struct packed {
    pix_t pix;
    logic sat;
  } div2_side_t;

endpackage

>>> hdl/rfta_div_pipe.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rfta_div_pipe #(
  parameter int unsigned W  = 12,
  parameter int unsigned QW = 28,
  parameter int unsigned SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [W-1:0]  in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [W-1:0]  in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo,
  output logic [W-1:0]  out_div,
  output logic [SW-1:0] out_side
);

  // one restoring step per stage; numerator bits shift out, quotient bits shift in
  logic          v_r    [QW];
  logic [W-1:0]  rem_r  [QW];
  logic [QW-1:0] nq_r   [QW];
  logic [W-1:0]  d_r    [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW:0]   rdy;

  assign rdy[QW] = out_ready;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_st
      logic          v_src;
      logic [W-1:0]  rem_src;
      logic [QW-1:0] nq_src;
      logic [W-1:0]  d_src;
      logic [SW-1:0] side_src;
      logic [W:0]    trial;
      logic          take;

      if (k == 0) begin : g_first
        assign v_src    = in_valid;
        assign rem_src  = in_rem;
        assign nq_src   = in_num;
        assign d_src    = in_div;
        assign side_src = in_side;
      end else begin : g_next
        assign v_src    = v_r[k-1];
        assign rem_src  = rem_r[k-1];
        assign nq_src   = nq_r[k-1];
        assign d_src    = d_r[k-1];
        assign side_src = side_r[k-1];
      end

      assign rdy[k] = ~v_r[k] | rdy[k+1];
      assign trial  = {rem_src, nq_src[QW-1]};
      assign take   = trial >= {1'b0, d_src};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_r[k] <= v_src;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem_r[k]  <= take ? W'(trial - {1'b0, d_src}) : trial[W-1:0];
          nq_r[k]   <= {nq_src[QW-2:0], take};
          d_r[k]    <= d_src;
          side_r[k] <= side_src;
        end
      end
    end
  endgenerate

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QW-1];
  assign out_quo   = nq_r[QW-1];
  assign out_div   = d_r[QW-1];
  assign out_side  = side_r[QW-1];

  `RFTA_ASSERT(a_rem_below_div, clk, rst_n, (out_valid && out_div != '0) |-> (rem_r[QW-1] < out_div), "divider remainder not below divisor")
  `RFTA_ASSERT(a_hold_on_stall, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_quo)), "divider result lost on stall")

endmodule

>>> hdl/rfta_lerp.sv
`timescale 1ns / 1ps
module rfta_lerp #(
  parameter int unsigned TEX_WIDTH  = 64,
  parameter int unsigned TEX_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [17:0]       in_wq,
  input  rfta_pkg::pix_t    in_pix,
  input  logic              in_sat,
  input  logic [23:0]       player_x,
  input  logic [23:0]       player_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [11:0]       out_texel,
  output rfta_pkg::pix_t    out_pix
);
  import rfta_pkg::*;

  localparam int unsigned TXW = (TEX_WIDTH  > 1) ? $clog2(TEX_WIDTH)  : 1;
  localparam int unsigned TYW = (TEX_HEIGHT > 1) ? $clog2(TEX_HEIGHT) : 1;
  localparam int unsigned PW  = POS_W + 17;
  localparam int unsigned MW  = 16 + 11;
  localparam int unsigned IW  = 21;

  logic v1_r, v2_r, v3_r, v4_r;
  logic r1, r2, r3, r4;
  pix_t p1_r, p2_r, p3_r, p4_r;

  assign r4 = ~v4_r | out_ready;
  assign r3 = ~v3_r | r4;
  assign r2 = ~v2_r | r3;
  assign r1 = ~v1_r | r2;
  assign in_ready = r1;

  // weight, saturated to 1.0
  logic [16:0] w;
  logic [16:0] w_inv;
  assign w     = (in_sat || in_wq > 18'(ONE_Q16)) ? ONE_Q16 : in_wq[16:0];
  assign w_inv = ONE_Q16 - w;

  // stage 1: the four products
  logic [PW-1:0] mwx_r, mpx_r, mwy_r, mpy_r;
  // stage 2: fractional part of the interpolated point
  logic [15:0] fx_r, fy_r;
  // stage 3: texture coordinates
  logic [TXW-1:0] tx_r;
  logic [TYW-1:0] ty_r;
  // stage 4: address
  logic [11:0] texel_r;

  logic [PW:0]   sum_x, sum_y;
  logic [MW-1:0] prod_x, prod_y;
  logic [IW-1:0] idx;

  assign sum_x  = {1'b0, mwx_r} + {1'b0, mpx_r};
  assign sum_y  = {1'b0, mwy_r} + {1'b0, mpy_r};
  assign prod_x = MW'(fx_r) * MW'(TEX_WIDTH);
  assign prod_y = MW'(fy_r) * MW'(TEX_HEIGHT);
  assign idx    = IW'(TEX_WIDTH) * IW'(ty_r) + IW'(tx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (r1) v1_r <= in_valid;
      if (r2) v2_r <= v1_r;
      if (r3) v3_r <= v2_r;
      if (r4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      mwx_r <= PW'(w) * PW'(in_pix.wall_x);
      mpx_r <= PW'(w_inv) * PW'(player_x);
      mwy_r <= PW'(w) * PW'(in_pix.wall_y);
      mpy_r <= PW'(w_inv) * PW'(player_y);
      p1_r  <= in_pix;
    end
    if (r2) begin
      fx_r <= sum_x[31:16];
      fy_r <= sum_y[31:16];
      p2_r <= p1_r;
    end
    if (r3) begin
      // frac * size / 2^16 is already below size, so no wrap needed
      tx_r <= prod_x[16 +: TXW];
      ty_r <= prod_y[16 +: TYW];
      p3_r <= p2_r;
    end
    if (r4) begin
      texel_r <= p3_r.vres ? idx[11:0] : 12'd0;
      p4_r    <= p3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_texel = texel_r;
  assign out_pix   = p4_r;

endmodule

>>> hdl/raycast_floor_texel_address.sv
// Stages from input transfer to result: front stage, 28 row-distance divider stages,
//   one setup stage, 18 weight divider stages, 4 interpolation stages.
// Throughput: one pixel per clock while out_tready is high; every stage holds its own valid and fills bubbles.
// A stall on the result side freezes only stages that are full.
// Reset (rst_n, synchronous, active low): pipeline emptied, screen_height 480,
//   player position 0.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module raycast_floor_texel_address #(
  parameter int unsigned TEX_WIDTH  = rfta_pkg::TEX_WIDTH_DEF,
  parameter int unsigned TEX_HEIGHT = rfta_pkg::TEX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // row[10:0] column[21:11] hit_side[22] dir_x_class[24:23] dir_y_positive[25]
  // cell_x[33:26] cell_y[41:34] hit_fraction[57:42] wall_distance[81:58]
  input  logic [87:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // texel_index[11:0] floor_row[22:12] ceiling_row[33:23] out_column[44:34]
  output logic [47:0] out_tdata,
  // valid_res[0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import rfta_pkg::*;

  // ---------------------------------------------------------------- config
  logic [11:0] screen_height_r;
  logic [23:0] player_x_r, player_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= SCREEN_HEIGHT_RST;
      player_x_r      <= '0;
      player_y_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[11:0];
        REG_PLAYER_X:      player_x_r      <= cfg_wdata;
        REG_PLAYER_Y:      player_y_r      <= cfg_wdata;
        default: ;  // index beyond the list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- unpack
  logic [10:0] i_row, i_col;
  logic        i_side, i_dyp;
  logic [1:0]  i_dxc;
  logic [7:0]  i_cx, i_cy;
  logic [15:0] i_frac;
  logic [23:0] i_wdist;

  assign i_row   = in_tdata[10:0];
  assign i_col   = in_tdata[21:11];
  assign i_side  = in_tdata[22];
  assign i_dxc   = in_tdata[24:23];
  assign i_dyp   = in_tdata[25];
  assign i_cx    = in_tdata[33:26];
  assign i_cy    = in_tdata[41:34];
  assign i_frac  = in_tdata[57:42];
  assign i_wdist = in_tdata[81:58];

  // ---------------------------------------------------------------- front stage
  // Wall base point from side and ray direction, horizon test, divisor 2y-H.
  logic [POS_W-1:0] wall_x, wall_y;
  logic [11:0]      row2, denom;
  logic             vres;

  always_comb begin
    if (!i_side && i_dxc == DIR_X_POS) begin
      wall_x = {1'b0, i_cx, 16'd0};
      wall_y = {1'b0, i_cy, i_frac};
    end else if (!i_side && i_dxc == DIR_X_NEG) begin
      wall_x = {9'({1'b0, i_cx} + 9'd1), 16'd0};
      wall_y = {1'b0, i_cy, i_frac};
    end else if (i_side && i_dyp) begin
      wall_x = {1'b0, i_cx, i_frac};
      wall_y = {1'b0, i_cy, 16'd0};
    end else begin
      // also zero x direction on a vertical line hit
      wall_x = {1'b0, i_cx, i_frac};
      wall_y = {9'({1'b0, i_cy} + 9'd1), 16'd0};
    end
  end

  assign row2  = {i_row, 1'b0};
  assign vres  = row2 > screen_height_r;
  // rows above the horizon divide by one; their result is masked later
  assign denom = vres ? (row2 - screen_height_r) : 12'd1;

  logic        f_v_r, f_rdy;
  div1_side_t  f_side_r;
  logic [11:0] f_denom_r;
  logic [11:0] f_h_r;
  logic        d1_in_rdy;

  assign f_rdy     = ~f_v_r | d1_in_rdy;
  assign in_tready = f_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (f_rdy) begin
      f_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_rdy) begin
      f_side_r.pix.row      <= i_row;
      f_side_r.pix.column   <= i_col;
      f_side_r.pix.ceil_row <= 11'(screen_height_r - {1'b0, i_row});
      f_side_r.pix.vres     <= vres;
      f_side_r.pix.wall_x   <= wall_x;
      f_side_r.pix.wall_y   <= wall_y;
      f_side_r.wdist        <= i_wdist;
      f_denom_r             <= denom;
      f_h_r                 <= screen_height_r;
    end
  end

  // ---------------------------------------------------------------- row_dist = H*2^16/(2y-H)
  logic              d1_out_v, m_rdy;
  logic [DIST_W-1:0] row_dist;
  logic [11:0]       d1_div_unused;
  div1_side_t        d1_side;

  rfta_div_pipe #(
    .W  (12),
    .QW (DIST_W),
    .SW ($bits(div1_side_t))
  ) u_div_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_v_r),
    .in_ready  (d1_in_rdy),
    .in_rem    (12'd0),
    .in_num    ({f_h_r, 16'd0}),
    .in_div    (f_denom_r),
    .in_side   (f_side_r),
    .out_valid (d1_out_v),
    .out_ready (m_rdy),
    .out_quo   (row_dist),
    .out_div   (d1_div_unused),
    .out_side  (d1_side)
  );

  // ---------------------------------------------------------------- setup for weight
  // Quotient of row_dist*2^16 / wdist fits 18 bits unless row_dist >= 4*wdist; that
  // case (and zero wall distance) saturates to 1.0 directly.
  logic        sat;
  logic        m_v_r, d2_in_rdy;
  div2_side_t  m_side_r;
  logic [23:0] m_rem_r, m_div_r;
  logic [17:0] m_num_r;

  assign sat   = row_dist >= {d1_side.wdist, 2'b00};
  assign m_rdy = ~m_v_r | d2_in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_rdy) begin
      m_v_r <= d1_out_v;
    end
  end

  always_ff @(posedge clk) begin
    if (m_rdy) begin
      m_side_r.pix <= d1_side.pix;
      m_side_r.sat <= sat;
      m_rem_r      <= sat ? 24'd0 : row_dist[25:2];
      m_num_r      <= {row_dist[1:0], 16'd0};
      m_div_r      <= d1_side.wdist;
    end
  end

  // ---------------------------------------------------------------- w = row_dist*2^16/wdist
  logic            d2_out_v, l_in_rdy;
  logic [WQ_W-1:0] wq;
  logic [23:0]     d2_div_unused;
  div2_side_t      d2_side;

  rfta_div_pipe #(
    .W  (24),
    .QW (WQ_W),
    .SW ($bits(div2_side_t))
  ) u_div_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_v_r),
    .in_ready  (d2_in_rdy),
    .in_rem    (m_rem_r),
    .in_num    (m_num_r),
    .in_div    (m_div_r),
    .in_side   (m_side_r),
    .out_valid (d2_out_v),
    .out_ready (l_in_rdy),
    .out_quo   (wq),
    .out_div   (d2_div_unused),
    .out_side  (d2_side)
  );

  // ---------------------------------------------------------------- interpolate and address
  logic [11:0] texel;
  pix_t        o_pix;

  rfta_lerp #(
    .TEX_WIDTH  (TEX_WIDTH),
    .TEX_HEIGHT (TEX_HEIGHT)
  ) u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d2_out_v),
    .in_ready  (l_in_rdy),
    .in_wq     (wq),
    .in_pix    (d2_side.pix),
    .in_sat    (d2_side.sat),
    .player_x  (player_x_r),
    .player_y  (player_y_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_texel (texel),
    .out_pix   (o_pix)
  );

  assign out_tdata = {3'd0, o_pix.column, o_pix.ceil_row, o_pix.row, texel};
  assign out_tuser = o_pix.vres;

  `RFTA_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `RFTA_ASSERT(a_invalid_zero_texel, clk, rst_n, (out_tvalid && !out_tuser) |-> (out_tdata[11:0] == 12'd0), "texel set on row above horizon")
  `RFTA_ASSERT(a_front_ready_when_empty, clk, rst_n, !f_v_r |-> in_tready, "front stage empty but not ready")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rfta_pkg::*;

  // one floor pixel as offered on the input stream
  typedef struct {
    logic [10:0] row;
    logic [10:0] column;
    logic        side;
    logic [1:0]  dxc;
    logic        dyp;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] frac;
    logic [23:0] wdist;
  } pixel_t;

  // predicted texel address result
  typedef struct {
    logic [11:0] texel;
    logic [10:0] floor_row;
    logic [10:0] ceil_row;
    logic [10:0] column;
    logic        vres;
  } texel_t;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT  = 60;   // pipeline depth plus margin

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [87:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  // mirror of the block's registers
  logic [11:0] scr_h = SCREEN_HEIGHT_RST;
  logic [23:0] pos_x = '0;
  logic [23:0] pos_y = '0;

  pixel_t pixels_pending[$];
  texel_t texels_due[$];
  pixel_t pix_on_bus;
  int     err_cnt = 0;
  int     quiet_cycles = 0;
  bit     calm = 1'b0;    // no idling on either side while set

  raycast_floor_texel_address u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [87:0] pack_pixel(pixel_t p);
    return {6'd0, p.wdist, p.frac, p.cell_y, p.cell_x, p.dyp, p.dxc, p.side,
            p.column, p.row};
  endfunction

  // texel address of one floor pixel under the current registers
  function automatic texel_t floor_texel(pixel_t p);
    longint unsigned cx, cy, wx, wy, h, row_dist, w, fx, fy, tx, ty;
    texel_t t;
    cx = longint'(p.cell_x) << 16;
    cy = longint'(p.cell_y) << 16;
    h  = scr_h;
    // floor point at the wall base
    if (p.side == 1'b0 && p.dxc == DIR_X_POS) begin
      wx = cx;           wy = cy + p.frac;
    end else if (p.side == 1'b0 && p.dxc == DIR_X_NEG) begin
      wx = cx + ONE_Q16; wy = cy + p.frac;
    end else if (p.side == 1'b1 && p.dyp) begin
      wx = cx + p.frac;  wy = cy;
    end else begin
      wx = cx + p.frac;  wy = cy + ONE_Q16;
    end
    t.texel = '0;
    t.vres  = 1'b0;
    if (2 * longint'(p.row) > h) begin
      row_dist = (h << 16) / (2 * longint'(p.row) - h);
      w = ONE_Q16;
      // zero wall distance saturates the weight
      if (p.wdist != 0) begin
        w = (row_dist << 16) / p.wdist;
        if (w > ONE_Q16) w = ONE_Q16;
      end
      fx = (w * wx + (ONE_Q16 - w) * pos_x) >> 16;
      fy = (w * wy + (ONE_Q16 - w) * pos_y) >> 16;
      tx = ((fx * TEX_WIDTH_DEF) >> 16) % TEX_WIDTH_DEF;
      ty = ((fy * TEX_HEIGHT_DEF) >> 16) % TEX_HEIGHT_DEF;
      t.texel = 12'(TEX_WIDTH_DEF * ty + tx);
      t.vres  = 1'b1;
    end
    t.floor_row = p.row;
    t.ceil_row  = 11'(h - p.row);
    t.column    = p.column;
    return t;
  endfunction

  // sender: next pending pixel, with random gaps
  always @(posedge clk) begin
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (pixels_pending.size() > 0 && (calm || $urandom_range(99) >= 21)) begin
        pix_on_bus <= pixels_pending[0];
        in_tdata   <= pack_pixel(pixels_pending.pop_front());
        in_tvalid  <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= rst_n && (calm || $urandom_range(99) >= 21);
  end

  // predict on input transfer, check on result transfer
  always @(posedge clk) begin
    texel_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) texels_due.push_back(floor_texel(pix_on_bus));
      if (out_tvalid && out_tready) begin
        if (texels_due.size() == 0) begin
          $display("%0t: unexpected result transfer, data %h user %b",
                   $time, out_tdata, out_tuser);
          err_cnt++;
        end else begin
          e = texels_due.pop_front();
          if (out_tdata[11:0] !== e.texel) begin
            $display("%0t: texel_index exp %0d got %0d", $time, e.texel, out_tdata[11:0]);
            err_cnt++;
          end
          if (out_tdata[22:12] !== e.floor_row) begin
            $display("%0t: floor_row exp %0d got %0d", $time, e.floor_row,
                     out_tdata[22:12]);
            err_cnt++;
          end
          if (out_tdata[33:23] !== e.ceil_row) begin
            $display("%0t: ceiling_row exp %0d got %0d", $time, e.ceil_row,
                     out_tdata[33:23]);
            err_cnt++;
          end
          if (out_tdata[44:34] !== e.column) begin
            $display("%0t: out_column exp %0d got %0d", $time, e.column,
                     out_tdata[44:34]);
            err_cnt++;
          end
          if (out_tuser !== e.vres) begin
            $display("%0t: valid_res exp %b got %b", $time, e.vres, out_tuser);
            err_cnt++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] addr, logic [23:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_SCREEN_HEIGHT: scr_h = data[11:0];
      REG_PLAYER_X:      pos_x = data;
      REG_PLAYER_Y:      pos_y = data;
      default: ;         // unused index, ignored by the block
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // idle point: all transfers done, pipeline drained
  task automatic drain();
    while (pixels_pending.size() > 0 || texels_due.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic pixel_t any_pixel();
    pixel_t p;
    p.row = 11'($urandom); p.column = 11'($urandom);
    p.side = 1'($urandom); p.dxc = 2'($urandom); p.dyp = 1'($urandom);
    p.cell_x = 8'($urandom); p.cell_y = 8'($urandom);
    p.frac = 16'($urandom); p.wdist = 24'($urandom);
    return p;
  endfunction

  // mostly rows under the horizon and plausible wall distances
  task automatic queue_random(int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p = any_pixel();
      if ($urandom_range(99) < 80) begin
        p.row = 11'($urandom_range(scr_h, scr_h / 2));
        case ($urandom_range(3))
          0: p.wdist = 24'($urandom_range(32'h4_0000, 1));
          1: p.wdist = 24'($urandom_range(32'h40_0000, 32'h1_0000));
          default: ;
        endcase
      end
      pixels_pending.push_back(p);
    end
  endtask

  task automatic queue_pixel(logic [10:0] row, logic side, logic [1:0] dxc, logic dyp,
                             logic [7:0] c, logic [15:0] frac, logic [23:0] wd);
    pixel_t p;
    p = any_pixel();
    p.row = row; p.side = side; p.dxc = dxc; p.dyp = dyp;
    p.cell_x = c; p.cell_y = ~c; p.frac = frac; p.wdist = wd;
    pixels_pending.push_back(p);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed pixels under reset registers (H 480, player at origin)
    queue_pixel(11'd0,    1'b0, 2'd0, 1'b0, 8'd0,   16'h0000, 24'h01_0000);
    queue_pixel(11'd240,  1'b0, 2'd1, 1'b0, 8'd255, 16'hFFFF, 24'h01_0000);
    queue_pixel(11'd241,  1'b0, 2'd2, 1'b1, 8'd17,  16'h8000, 24'h01_0000);
    queue_pixel(11'd241,  1'b0, 2'd3, 1'b0, 8'd200, 16'h1234, 24'hFF_FFFF);
    queue_pixel(11'd300,  1'b1, 2'd0, 1'b1, 8'd255, 16'hFFFF, 24'd1);
    queue_pixel(11'd300,  1'b1, 2'd1, 1'b0, 8'd0,   16'h0001, 24'd0);
    queue_pixel(11'd479,  1'b1, 2'd3, 1'b1, 8'd99,  16'hABCD, 24'h00_8000);
    queue_pixel(11'd480,  1'b0, 2'd0, 1'b1, 8'd5,   16'h7FFF, 24'h03_0000);
    queue_pixel(11'd481,  1'b1, 2'd2, 1'b0, 8'd128, 16'h4000, 24'h10_0000);
    queue_pixel(11'd2047, 1'b0, 2'd1, 1'b1, 8'd255, 16'hFFFF, 24'hFF_FFFF);
    queue_pixel(11'd2047, 1'b1, 2'd0, 1'b0, 8'd1,   16'h0000, 24'd0);
    queue_pixel(11'd1024, 1'b0, 2'd3, 1'b1, 8'd77,  16'hC000, 24'h00_0100);
    drain();

    // smallest screen, player at the far corner; unused index written too
    write_reg(REG_SCREEN_HEIGHT, 24'd2);
    write_reg(REG_PLAYER_X, 24'hFF_FFFF);
    write_reg(REG_PLAYER_Y, 24'hFF_FFFF);
    write_reg(2'd3, 24'h00_0007);
    queue_pixel(11'd0, 1'b0, 2'd0, 1'b0, 8'd3, 16'h0000, 24'd1);
    queue_pixel(11'd1, 1'b1, 2'd1, 1'b1, 8'd3, 16'hFFFF, 24'd1);
    queue_pixel(11'd2, 1'b1, 2'd2, 1'b0, 8'd3, 16'h0100, 24'd0);
    queue_random(100);
    drain();

    // largest screen, long stretch with no idling
    write_reg(REG_SCREEN_HEIGHT, 24'd2048);
    write_reg(REG_PLAYER_X, 24'h00_0000);
    write_reg(REG_PLAYER_Y, 24'hFF_FFFF);
    calm = 1'b1;
    queue_pixel(11'd1024, 1'b0, 2'd0, 1'b0, 8'd10, 16'h0000, 24'd1);
    queue_pixel(11'd1025, 1'b0, 2'd1, 1'b0, 8'd10, 16'h0000, 24'd1);
    queue_random(120);
    drain();
    calm = 1'b0;

    // random registers
    for (int k = 0; k < 2; k++) begin
      write_reg(REG_SCREEN_HEIGHT, 24'($urandom_range(2048, 2)));
      write_reg(REG_PLAYER_X, 24'($urandom));
      write_reg(REG_PLAYER_Y, 24'($urandom));
      queue_random(100);
      drain();
    end

    // back to a typical window, player mid-map
    write_reg(REG_SCREEN_HEIGHT, 24'd480);
    write_reg(REG_PLAYER_X, 24'h0C_8000);
    write_reg(REG_PLAYER_Y, 24'h21_4000);
    queue_random(80);
    drain();

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
